@@ rtl/core/chunk_container_checker_core_assert.svh @@
// Assertion macros shared by the chunk container checker RTL.
// Depends on nothing; each use names its own clock and active-low reset.
`ifndef CHUNK_CONTAINER_CHECKER_CORE_ASSERT_SVH
`define CHUNK_CONTAINER_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccc assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is held.
`define CCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccc assertion failed (next cycle)");

`endif

@@ rtl/core/ccc_pkg.sv @@
// Package of the chunk container checker: codes, constants, result types, hash mix.
// Used by ccc_parser, ccc_fifo and chunk_container_checker_core.
`default_nettype none

package ccc_pkg;

    localparam logic [31:0] HASH_MUL        = 32'hC2B0C3CC;
    localparam logic [31:0] HASH_INIT       = 32'd1;
    localparam logic [31:0] END_CHUNK_BYTES = 32'd12;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TYPE    = 2'd1;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_CHUNK   = 2'd1;
    localparam logic [1:0] KIND_FILE    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_OVERRUN   = 3'd2;
    localparam logic [2:0] ERR_HASH      = 3'd3;
    localparam logic [2:0] ERR_EARLY_END = 3'd4;
    localparam logic [2:0] ERR_TRUNC     = 3'd5;
    localparam logic [2:0] ERR_END_LEN   = 3'd6;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_HASH,
        PH_STOP
    } t_phase;

    typedef struct packed {
        logic [31:0] file_length;
        logic [31:0] end_type;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] chunk_kind;
        logic [7:0]  out_byte;
        logic [2:0]  error_code;
        logic        run_end;
    } t_result;

    // Multiply by the hash constant and fold the 64-bit product.
    function automatic logic [31:0] mix(input logic [31:0] h);
        logic [63:0] p;
        p = {32'd0, h} * {32'd0, HASH_MUL};
        return p[31:0] ^ p[63:32];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ccc_parser.sv @@
// Front end: takes one byte per beat, tracks the chunk structure and hash,
// and emits at most one result per byte. Depends on ccc_pkg and the assert header.
`default_nettype none
`include "chunk_container_checker_core_assert.svh"

module ccc_parser
    import ccc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire t_cfg    i_cfg,
    output logic         o_push,
    output t_result      o_result
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos;
    logic [2:0]  r_hidx;
    logic [1:0]  r_kidx;
    logic [31:0] r_left;
    logic [31:0] r_type;
    logic [31:0] r_plen;
    logic [31:0] r_hash;
    logic [1:0]  r_lane;
    logic [31:0] r_rx;
    logic [31:0] r_fhash;
    logic        r_in_final;
    logic [32:0] r_need;

    logic        start;
    logic [31:0] base_hash, base_type, base_plen;
    logic [1:0]  base_lane;
    logic [31:0] xored, mul_in, mixed, hashed;
    logic [31:0] type_new, plen_new, rx_new;
    logic [31:0] fl_m12;
    logic        fl_short, past_end, at_end, overrun;
    logic [33:0] need_sum;

    logic        fail, emit, to_hash, to_payload, to_header, to_stop;
    logic [2:0]  fail_code;
    logic [1:0]  emit_kind;
    logic [31:0] res_type;

    // Hash datapath: one lane xor, one shared multiplier
    always_comb begin
        start     = (r_phase == PH_HEADER) && (r_hidx == 3'd0);
        base_hash = start ? HASH_INIT : r_hash;
        base_lane = start ? 2'd0 : r_lane;
        base_type = start ? 32'd0 : r_type;
        base_plen = start ? 32'd0 : r_plen;
        xored     = base_hash ^ ({24'd0, i_in_byte} << {base_lane, 3'b000});
        mul_in    = (r_phase == PH_HASH) ? r_hash : xored;
        mixed     = mix(mul_in);
        hashed    = (base_lane == 2'd3) ? mixed : xored;
        type_new  = {base_type[23:0], i_in_byte};
        plen_new  = {base_plen[23:0], i_in_byte};
        rx_new    = {r_rx[23:0], i_in_byte};
        fl_short  = i_cfg.file_length < END_CHUNK_BYTES;
        fl_m12    = i_cfg.file_length - END_CHUNK_BYTES;
        past_end  = r_pos > fl_m12;
        at_end    = r_pos == fl_m12;
        need_sum  = {2'b00, plen_new} + {1'b0, r_need};
        overrun   = (plen_new != 32'd0) && (need_sum > {2'b00, i_cfg.file_length});
    end

    // Classify the byte
    always_comb begin
        fail       = 1'b0;
        fail_code  = ERR_NONE;
        emit       = 1'b0;
        emit_kind  = KIND_PAYLOAD;
        to_hash    = 1'b0;
        to_payload = 1'b0;
        to_header  = 1'b0;
        to_stop    = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                if (start && fl_short) begin
                    fail      = 1'b1;
                    fail_code = ERR_SHORT;
                end else if (start && past_end) begin
                    fail      = 1'b1;
                    fail_code = ERR_TRUNC;
                end else if (r_hidx == 3'd3 && r_in_final && type_new != i_cfg.end_type) begin
                    fail      = 1'b1;
                    fail_code = ERR_TRUNC;
                end else if (r_hidx == 3'd7) begin
                    if (r_in_final) begin
                        if (plen_new != 32'd0) begin
                            fail      = 1'b1;
                            fail_code = ERR_END_LEN;
                        end else begin
                            to_hash = 1'b1;
                        end
                    end else if (overrun) begin
                        fail      = 1'b1;
                        fail_code = ERR_OVERRUN;
                    end else if (plen_new == 32'd0) begin
                        to_hash = 1'b1;
                    end else begin
                        to_payload = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                emit      = 1'b1;
                emit_kind = KIND_PAYLOAD;
                to_hash   = (r_left == 32'd1);
            end
            PH_HASH: begin
                if (r_kidx == 2'd3) begin
                    if (rx_new != r_fhash) begin
                        fail      = 1'b1;
                        fail_code = ERR_HASH;
                    end else if (r_in_final) begin
                        emit      = 1'b1;
                        emit_kind = KIND_FILE;
                        to_stop   = 1'b1;
                    end else if (r_type == i_cfg.end_type) begin
                        fail      = 1'b1;
                        fail_code = ERR_EARLY_END;
                    end else begin
                        emit      = 1'b1;
                        emit_kind = KIND_CHUNK;
                        to_header = 1'b1;
                    end
                end
            end
            PH_STOP: begin
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (fail || to_stop) begin
                n_phase = PH_STOP;
            end else if (to_hash) begin
                n_phase = PH_HASH;
            end else if (to_payload) begin
                n_phase = PH_PAYLOAD;
            end else if (to_header) begin
                n_phase = PH_HEADER;
            end
        end
    end

    // Result toward the queue
    always_comb begin
        if (r_phase == PH_HEADER && !r_hidx[2]) begin
            res_type = start ? 32'd0 : type_new;
        end else begin
            res_type = r_type;
        end
        o_push              = i_accept && (fail || emit);
        o_result.kind       = fail ? KIND_ERROR : emit_kind;
        o_result.chunk_kind = res_type;
        o_result.out_byte   = (!fail && emit_kind == KIND_PAYLOAD) ? i_in_byte : 8'd0;
        o_result.error_code = fail ? fail_code : ERR_NONE;
        o_result.run_end    = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_pos      <= 32'd0;
            r_hidx     <= 3'd0;
            r_kidx     <= 2'd0;
            r_in_final <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= r_pos + 32'd1;
            if (r_phase == PH_HEADER) begin
                r_hidx <= r_hidx + 3'd1;
                if (start) begin
                    r_in_final <= at_end;
                end
            end
            if (to_hash) begin
                r_kidx <= 2'd0;
            end else if (r_phase == PH_HASH) begin
                r_kidx <= r_kidx + 2'd1;
            end
            if (to_header) begin
                r_hidx <= 3'd0;
            end
        end
    end

    // Payload registers: hash, fields, counters
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    r_hash <= hashed;
                    r_lane <= base_lane + 2'd1;
                    r_type <= r_hidx[2] ? base_type : type_new;
                    r_plen <= r_hidx[2] ? plen_new : base_plen;
                    if (start) begin
                        r_need <= {1'b0, r_pos} + {1'b0, END_CHUNK_BYTES};
                    end
                    if (to_payload) begin
                        r_left <= plen_new;
                    end
                end
                PH_PAYLOAD: begin
                    r_hash <= hashed;
                    r_lane <= r_lane + 2'd1;
                    r_left <= r_left - 32'd1;
                end
                PH_HASH: begin
                    r_rx <= rx_new;
                    if (r_kidx == 2'd0) begin
                        r_fhash <= (r_lane != 2'd0) ? mixed : r_hash;
                    end
                end
                PH_STOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    `CCC_ASSERT_NXT(a_stop_sticks, i_clk, i_rst_n, r_phase == PH_STOP, r_phase == PH_STOP)
    `CCC_ASSERT_IMP(a_payload_left, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_left != 32'd0)
    `CCC_ASSERT_IMP(a_err_coded, i_clk, i_rst_n, o_push && o_result.kind == KIND_ERROR, o_result.error_code != ERR_NONE)
    `CCC_ASSERT_NXT(a_stop_silent, i_clk, i_rst_n, r_phase == PH_STOP && i_accept, !o_push)

endmodule

`default_nettype wire

@@ rtl/core/ccc_fifo.sv @@
// Result queue between the parser and the output port.
// Depends on ccc_pkg for the result type and depth.
`default_nettype none

module ccc_fifo
    import ccc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop,
    output logic         o_full,
    output logic         o_valid,
    output t_result      o_data
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_count;
    logic               do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/chunk_container_checker_core.sv @@
// Top level of the chunk container checker: configuration registers, parser, result queue.
// Depends on ccc_pkg, ccc_parser and ccc_fifo.
`default_nettype none

// Checks a stream of chunk data, one byte per input beat, against a file length
// and end-chunk type written beforehand on the configuration port (index 0:
// file length, index 1: end chunk type; other indexes are ignored). Each chunk
// is a big-endian type, a big-endian payload length, the payload and a 32-bit
// hash over type, length and payload. Every payload byte comes out as a beat of
// kind payload tagged with its chunk type; each chunk ends with a beat of kind
// chunk accepted, the end chunk in the last 12 bytes with file accepted, and any
// fault with one error beat carrying its code. After a verdict of file accepted
// or any error the block takes further bytes and drops them silently until reset.
// Rate: one byte per clock, sustained. Each byte passes through the parser,
// whose longest path is one lane xor into the 32x32 hash multiplier and fold;
// results then sit in a four-entry queue, and the input stalls only while that
// queue is full. The result beat of an accepted byte is registered in that queue.
module chunk_container_checker_core
    import ccc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_in_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_kind,
    output logic [31:0]               o_chunk_kind,
    output logic [7:0]                o_out_byte,
    output logic [2:0]                o_error_code,
    output logic                      o_run_end
);

    t_cfg    r_cfg;
    logic    accept;
    logic    push;
    logic    full;
    t_result res_in;
    t_result res_out;

    // Configuration: take writes immediately, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.file_length <= 32'd0;
            r_cfg.end_type    <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FILE_LENGTH: r_cfg.file_length <= i_cfg_data;
                CFG_END_TYPE:    r_cfg.end_type    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Hold input while the queue has no room for a possible result
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    ccc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_cfg     (r_cfg),
        .o_push    (push),
        .o_result  (res_in)
    );

    ccc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res_in),
        .i_pop   (!i_out_stall),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_data  (res_out)
    );

    assign o_kind       = res_out.kind;
    assign o_chunk_kind = res_out.chunk_kind;
    assign o_out_byte   = res_out.out_byte;
    assign o_error_code = res_out.error_code;
    assign o_run_end    = res_out.run_end;

endmodule

`default_nettype wire

@@ sim/chunk_container_checker_core_watch.sv @@
// Result watcher for the chunk container checker: follows the config port and both
// beat channels, predicts each result beat and compares it field by field.
// Depends on ccc_pkg for the port types, codes and hash constants.
module chunk_container_checker_core_watch
    import ccc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [1:0]           i_kind,
    input  logic [31:0]          i_chunk_kind,
    input  logic [7:0]           i_out_byte,
    input  logic [2:0]           i_error_code,
    input  logic                 i_run_end,
    output int                   o_mismatches,
    output int                   o_awaiting,
    output int                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_CAP = 40;

    logic [31:0] file_len;
    logic [31:0] end_kind;
    logic [31:0] stream_pos;
    logic [31:0] bytes_left;
    logic [31:0] chunk_kind;
    logic [31:0] body_len;
    logic [31:0] digest;
    logic [31:0] sent_digest;
    logic [1:0]  lane;
    logic        at_final;
    t_phase      phase;
    t_result     awaited_beats[$];

    function automatic logic [31:0] fold_product(input logic [31:0] h);
        logic [63:0] prod;
        prod = {32'd0, h} * {32'd0, HASH_MUL};
        return prod[31:0] ^ prod[63:32];
    endfunction

    task automatic absorb(input logic [7:0] b);
        digest = digest ^ ({24'd0, b} << (8 * lane));
        lane   = lane + 2'd1;
        if (lane == 2'd0) digest = fold_product(digest);
    endtask

    task automatic await_beat(input logic [1:0] kind, input logic [7:0] data,
                              input logic [2:0] code);
        t_result r;
        r.kind       = kind;
        r.chunk_kind = chunk_kind;
        r.out_byte   = data;
        r.error_code = code;
        r.run_end    = 1'b1;
        awaited_beats.push_back(r);
    endtask

    // Any fault freezes the stream until reset.
    task automatic raise_fault(input logic [2:0] code);
        phase = PH_STOP;
        await_beat(KIND_ERROR, 8'd0, code);
    endtask

    task automatic track_byte(input logic [7:0] b);
        logic [31:0] at;
        logic [31:0] idx;
        logic [31:0] sealed;
        logic [63:0] need;
        logic [63:0] room;
        at         = stream_pos;
        stream_pos = stream_pos + 32'd1;
        case (phase)
            PH_HEADER: begin
                if (bytes_left == 32'd0) begin
                    chunk_kind  = 32'd0;
                    body_len    = 32'd0;
                    digest      = HASH_INIT;
                    lane        = 2'd0;
                    sent_digest = 32'd0;
                    if (file_len < END_CHUNK_BYTES) begin
                        raise_fault(ERR_SHORT);
                    end else if (at > file_len - END_CHUNK_BYTES) begin
                        raise_fault(ERR_TRUNC);
                    end else begin
                        at_final   = (at == file_len - END_CHUNK_BYTES);
                        bytes_left = 32'd8;
                    end
                end
                if (phase == PH_HEADER) begin
                    idx        = 32'd8 - bytes_left;
                    bytes_left = bytes_left - 32'd1;
                    absorb(b);
                    if (idx < 32'd4) chunk_kind = {chunk_kind[23:0], b};
                    else             body_len   = {body_len[23:0], b};
                    if (idx == 32'd3 && at_final && chunk_kind != end_kind) begin
                        raise_fault(ERR_TRUNC);
                    end else if (idx == 32'd7) begin
                        if (at_final) begin
                            if (body_len != 32'd0) begin
                                raise_fault(ERR_END_LEN);
                            end else begin
                                phase      = PH_HASH;
                                bytes_left = 32'd4;
                            end
                        end else begin
                            // room left before the end chunk, from the chunk's first byte
                            need = {32'd0, at} - 64'd7 + {32'd0, END_CHUNK_BYTES};
                            room = (need <= {32'd0, file_len}) ? {32'd0, file_len} - need
                                                               : 64'd0;
                            if ({32'd0, body_len} > room) begin
                                raise_fault(ERR_OVERRUN);
                            end else if (body_len == 32'd0) begin
                                phase      = PH_HASH;
                                bytes_left = 32'd4;
                            end else begin
                                phase      = PH_PAYLOAD;
                                bytes_left = body_len;
                            end
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                absorb(b);
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0) begin
                    phase      = PH_HASH;
                    bytes_left = 32'd4;
                end
                await_beat(KIND_PAYLOAD, b, ERR_NONE);
            end
            PH_HASH: begin
                sent_digest = {sent_digest[23:0], b};
                bytes_left  = bytes_left - 32'd1;
                if (bytes_left == 32'd0) begin
                    sealed = (lane != 2'd0) ? fold_product(digest) : digest;
                    digest = sealed;
                    lane   = 2'd0;
                    if (sent_digest != sealed) begin
                        raise_fault(ERR_HASH);
                    end else if (at_final) begin
                        phase = PH_STOP;
                        await_beat(KIND_FILE, 8'd0, ERR_NONE);
                    end else if (chunk_kind == end_kind) begin
                        raise_fault(ERR_EARLY_END);
                    end else begin
                        phase      = PH_HEADER;
                        bytes_left = 32'd0;
                        await_beat(KIND_CHUNK, 8'd0, ERR_NONE);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic record_mismatch(input string msg);
        o_mismatches++;
        if (o_mismatches <= REPORT_CAP) $error("%s", msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
            record_mismatch($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    task automatic compare_beat();
        t_result want;
        o_checked++;
        if (awaited_beats.size() == 0) begin
            record_mismatch($sformatf("result beat with nothing awaited: kind %0d, type 0x%08h",
                                      i_kind, i_chunk_kind));
        end else begin
            want = awaited_beats.pop_front();
            compare_field("kind", 32'(want.kind), 32'(i_kind));
            compare_field("chunk_kind", want.chunk_kind, i_chunk_kind);
            compare_field("out_byte", 32'(want.out_byte), 32'(i_out_byte));
            compare_field("error_code", 32'(want.error_code), 32'(i_error_code));
            compare_field("run_end", 32'(want.run_end), 32'(i_run_end));
        end
    endtask

    // Sample everything on the edge itself: all drivers update after it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            file_len    = 32'd0;
            end_kind    = 32'd0;
            stream_pos  = 32'd0;
            bytes_left  = 32'd0;
            chunk_kind  = 32'd0;
            body_len    = 32'd0;
            digest      = HASH_INIT;
            sent_digest = 32'd0;
            lane        = 2'd0;
            at_final    = 1'b0;
            phase       = PH_HEADER;
            awaited_beats.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FILE_LENGTH)   file_len = i_cfg_data;
                else if (i_cfg_index == CFG_END_TYPE) end_kind = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) track_byte(i_in_byte);
            if (i_out_valid && !i_out_stall) compare_beat();
        end
        o_awaiting = awaited_beats.size();
    end

endmodule

@@ sim/chunk_container_checker_core_test.sv @@
// Testbench top for chunk_container_checker_core: clock, reset, register writes and byte stimulus.
// Depends on ccc_pkg, the block itself and chunk_container_checker_core_watch.
module chunk_container_checker_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ccc_pkg::*;

    // Indexes past the register list; the block must ignore them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASE_BYTES   = 620;

    // How the last phase of the stream ends; one is drawn per run.
    typedef enum int {
        CLOSE_CLEAN,
        CLOSE_BAD_DIGEST,
        CLOSE_END_LENGTH,
        CLOSE_WRONG_TYPE,
        CLOSE_BAD_CHUNK,
        CLOSE_EARLY_END,
        CLOSE_OVERRUN,
        CLOSE_SHRUNK,
        CLOSE_TOO_SHORT
    } t_closing;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_LIGHT,
        DRAIN_HEAVY
    } t_drain;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic [7:0]           i_in_byte   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_kind;
    logic [31:0]          o_chunk_kind;
    logic [7:0]           o_out_byte;
    logic [2:0]           o_error_code;
    logic                 o_run_end;

    int mismatch_total;
    int awaiting_beats;
    int checked_beats;

    logic [7:0] stream_q[$];
    int         burst_left     = 0;
    int         accepted_bytes = 0;
    int         chunk_count    = 0;

    always #5 i_clk = ~i_clk;

    chunk_container_checker_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_chunk_kind (o_chunk_kind),
        .o_out_byte   (o_out_byte),
        .o_error_code (o_error_code),
        .o_run_end    (o_run_end)
    );

    chunk_container_checker_core_watch u_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_kind       (o_kind),
        .i_chunk_kind (o_chunk_kind),
        .i_out_byte   (o_out_byte),
        .i_error_code (o_error_code),
        .i_run_end    (o_run_end),
        .o_mismatches (mismatch_total),
        .o_awaiting   (awaiting_beats),
        .o_checked    (checked_beats)
    );

    // Stimulus needs valid digests too, so keep a small copy of the fold here.
    function automatic logic [31:0] fold_product(input logic [31:0] h);
        logic [63:0] prod;
        prod = {32'd0, h} * {32'd0, HASH_MUL};
        return prod[31:0] ^ prod[63:32];
    endfunction

    // Append a big-endian word to the pending stream.
    task automatic put_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) stream_q.push_back(w[8*k +: 8]);
    endtask

    // Append one chunk with a random body; spoil flips one bit of its digest.
    task automatic add_chunk(input logic [31:0] kind, input logic [31:0] body,
                             input bit spoil);
        int          first;
        int          lane;
        logic [31:0] h;
        first = stream_q.size();
        put_word(kind);
        put_word(body);
        for (int k = 0; k < body; k++) stream_q.push_back(8'($urandom_range(0, 255)));
        h    = HASH_INIT;
        lane = 0;
        for (int k = first; k < stream_q.size(); k++) begin
            h    = h ^ ({24'd0, stream_q[k]} << (8 * lane));
            lane = (lane + 1) % 4;
            if (lane == 0) h = fold_product(h);
        end
        if (lane != 0) h = fold_product(h);
        if (spoil) h = h ^ (32'd1 << $urandom_range(0, 31));
        put_word(h);
        chunk_count++;
    endtask

    // Any type but the end marker.
    function automatic logic [31:0] pick_kind(input logic [31:0] marker);
        logic [31:0] k;
        do k = $urandom(); while (k == marker);
        return k;
    endfunction

    // Mostly short bodies, now and then a longer one.
    function automatic int pick_body();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
    endfunction

    task automatic add_random_chunks(input int budget, input logic [31:0] marker);
        while (stream_q.size() < budget) add_chunk(pick_kind(marker), pick_body(), 1'b0);
    endtask

    // Offer one beat and hold it until taken. Stall is read at the falling edge,
    // where everything has settled, so the beat is taken at the next rising edge.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        burst_left--;
        accepted_bytes++;
    endtask

    task automatic send_stream();
        while (stream_q.size() > 0) push_byte(stream_q.pop_front());
        i_in_valid <= 1'b0;
    endtask

    // Write one register; drop the enable again before the next write.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every awaited beat has come out, then let the pipeline go quiet.
    task automatic settle();
        @(posedge i_clk);
        while (awaiting_beats != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: switch between free flow, light and heavy back-pressure.
    initial begin
        t_drain drain;
        int     span;
        drain = DRAIN_FREE;
        span  = 0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                drain = t_drain'($urandom_range(0, 2));
                span  = $urandom_range(16, 256);
            end
            span--;
            case (drain)
                DRAIN_FREE:  i_out_stall <= 1'b0;
                DRAIN_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                default:     i_out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial begin
        t_closing    closing;
        logic [31:0] marker;
        logic [31:0] total;
        int          base;
        int          waited;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed start: both registers at their top value, the spare indexes
        // loaded with values that would break the stream if they aliased, then
        // an empty chunk of type zero and a chunk with a partial tail word.
        cfg_write(CFG_FILE_LENGTH, 32'hFFFF_FFFF);
        cfg_write(CFG_END_TYPE, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARE_LO, 32'd5);
        cfg_write(CFG_SPARE_HI, 32'd0);
        add_chunk(32'h0000_0000, 32'd0, 1'b0);
        add_chunk(32'h00FF_A55A, 32'd3, 1'b0);
        send_stream();
        settle();

        // End marker at zero, a random roomy file length.
        cfg_write(CFG_END_TYPE, 32'd0);
        cfg_write(CFG_FILE_LENGTH, $urandom_range(32'h0001_0000, 32'hFFFF_0000));
        add_random_chunks(PHASE_BYTES, 32'd0);
        send_stream();
        settle();

        // Last phase: random marker and a file length that puts the end chunk
        // exactly at the tail (or further out for a shrink), then one closing case drawn at random.
        marker  = $urandom();
        closing = t_closing'($urandom_range(0, 8));
        add_random_chunks(PHASE_BYTES, marker);
        base = accepted_bytes;
        case (closing)
            CLOSE_CLEAN:      add_chunk(marker, 32'd0, 1'b0);
            CLOSE_BAD_DIGEST: add_chunk(marker, 32'd0, 1'b1);
            CLOSE_END_LENGTH: begin
                put_word(marker);
                put_word(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 255));
                put_word($urandom());
            end
            CLOSE_WRONG_TYPE: add_chunk(pick_kind(marker), 32'd0, 1'b0);
            CLOSE_BAD_CHUNK: begin
                add_chunk(pick_kind(marker), pick_body(), 1'b1);
                add_chunk(marker, 32'd0, 1'b0);
            end
            CLOSE_EARLY_END: begin
                add_chunk(marker, pick_body(), 1'b0);
                add_chunk(marker, 32'd0, 1'b0);
            end
            CLOSE_OVERRUN: begin
                // only 8 bytes of room remain ahead of the end chunk
                put_word(pick_kind(marker));
                put_word(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(9, 300));
                repeat (12) stream_q.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        total = base + stream_q.size();
        if (closing == CLOSE_SHRUNK || closing == CLOSE_TOO_SHORT)
            total = total + $urandom_range(12, 500);
        cfg_write(CFG_END_TYPE, marker);
        cfg_write(CFG_FILE_LENGTH, total);

        // Shrink the file under the running stream while it sits between chunks.
        if (closing == CLOSE_SHRUNK || closing == CLOSE_TOO_SHORT) begin
            send_stream();
            settle();
            if (closing == CLOSE_SHRUNK)
                cfg_write(CFG_FILE_LENGTH, accepted_bytes + 11 - $urandom_range(0, 11));
            else
                cfg_write(CFG_FILE_LENGTH, $urandom_range(0, 11));
        end

        // Bytes past the verdict must vanish without a beat; without a shrink
        // they follow the closing chunk in the same run.
        repeat ($urandom_range(4, 24)) stream_q.push_back(8'($urandom_range(0, 255)));
        send_stream();

        // Drain what is still awaited, bounded, then give stray beats a chance.
        waited = 0;
        @(posedge i_clk);
        while (awaiting_beats != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (awaiting_beats != 0) $error("%0d result beats never arrived", awaiting_beats);

        $display("Streamed %0d bytes in %0d chunks under three register settings;",
                 accepted_bytes, chunk_count);
        $display("%0d beats checked.", checked_beats);
        $display("Stream closed on case %s, then took bytes past its end.", closing.name());
        if (mismatch_total == 0 && awaiting_beats == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
